>>> hw/rtl/radix_string_to_u128_parser_assert.svh
// Assertion macros shared by the parser RTL.
`ifndef RADIX_STRING_TO_U128_PARSER_ASSERT_SVH
`define RADIX_STRING_TO_U128_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on aclk and off while aresetn is low.
`define RSTU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and off while aresetn is low.
`define RSTU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rstu128_pkg.sv
// Types, codes and the default symbol map for the radix string parser.
`timescale 1ns / 1ps

package rstu128_pkg;

    // Symbol map geometry.
    localparam int MAP_DEPTH   = 256;
    localparam int MAP_ADDR_W  = 8;

    // Symbol classes stored in the map.
    typedef enum logic [1:0] {
        CLS_DIGIT = 2'd0,
        CLS_SKIP  = 2'd1,
        CLS_MINUS = 2'd2,
        CLS_BAD   = 2'd3
    } sym_class_t;

    typedef struct packed {
        sym_class_t  cls;
        logic [7:0]  value;
    } map_entry_t;

    // Parse phases.
    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2,
        PH_BAD    = 2'd3
    } parse_phase_t;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // Request kinds carried in tuser.
    localparam logic REQ_CHAR     = 1'b0;
    localparam logic REQ_MAP_LOAD = 1'b1;

    // Register indexes (paddr bit 2).
    localparam logic REG_RADIX       = 1'b0;
    localparam logic REG_SIGN_ENABLE = 1'b1;

    // Register reset values.
    localparam logic [8:0] RADIX_RESET       = 9'd10;
    localparam logic       SIGN_ENABLE_RESET = 1'b1;

    // Character codes of the default map.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Map entry seen after reset for a character that was never loaded.
    function automatic map_entry_t default_entry(input logic [7:0] code);
        map_entry_t entry;
        entry.cls   = CLS_BAD;
        entry.value = 8'd0;
        case (code) inside
            [CHAR_ZERO:CHAR_NINE]: begin
                entry.cls   = CLS_DIGIT;
                entry.value = code - CHAR_ZERO;
            end
            CHAR_SPACE, CHAR_CR, CHAR_TAB, CHAR_FF, CHAR_VT, CHAR_LF, CHAR_PLUS: begin
                entry.cls = CLS_SKIP;
            end
            CHAR_MINUS: begin
                entry.cls = CLS_MINUS;
            end
            default: begin
                entry.cls = CLS_BAD;
            end
        endcase
        return entry;
    endfunction

endpackage

>>> hw/rtl/radix_string_to_u128_parser.sv
// Radix string to 128-bit unsigned parser, one character item per cycle unless a result waits on m_tready.
// A result reaches the output register after the last character passes through stage 1.
// Throughput: one item per cycle when not stalled, set by the combinational 128x9 multiply-add.
// The symbol map memory is read at accept into rd_entry_reg, which stage 1 then uses.
// Reset: registers return to radix 10 and signs enabled, parse state clears, and
// per-entry valid bits make the whole map read as its default at once (no clearing pass).
`timescale 1ns / 1ps
`include "radix_string_to_u128_parser_assert.svh"

module radix_string_to_u128_parser
    import rstu128_pkg::*;
#(
    parameter longint unsigned MAX_LENGTH = 65535
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // char_code[7:0], entry_class[9:8], entry_value[17:10], zeros
    input  logic         s_tuser,   // req_type
    input  logic         s_tlast,   // last_char
    // Result channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // value_low[63:0], value_high[127:64], negative_flag[128],
                                    // status[130:129], end_count[146:131], zeros
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [15:0] COUNT_LIMIT = 16'((MAX_LENGTH > 64'd65535) ? 64'd65535 : MAX_LENGTH);

    // Configuration registers.
    logic [8:0] radix_reg;
    logic       sign_enable_reg;

    // Symbol map memory and its valid bits.
    map_entry_t             map_mem [MAP_DEPTH];
    logic [MAP_DEPTH-1:0]   map_valid_reg;
    map_entry_t             rd_entry_reg;
    logic                   rd_hit_reg;

    // Stage 1 control.
    logic                   s1_valid_reg;
    logic                   s1_load_reg;
    logic                   s1_last_reg;
    logic [MAP_ADDR_W-1:0]  s1_code_reg;

    // Parse state.
    parse_phase_t phase_reg, phase_next;
    logic [127:0] accum_reg, accum_next;
    logic         sign_reg, sign_next;
    logic         ovf_reg, ovf_next;
    logic [15:0]  count_reg, count_next;
    logic [15:0]  mark_reg, mark_next;

    // Output register.
    logic         m_tvalid_reg;
    logic [63:0]  m_value_low_reg;
    logic [63:0]  m_value_high_reg;
    logic         m_negative_reg;
    logic [1:0]   m_status_reg;
    logic [15:0]  m_end_count_reg;

    // Input field views.
    logic [7:0]   in_code;
    map_entry_t   in_entry;
    logic         s_accept;

    // Stage 1 working signals.
    map_entry_t   entry;
    logic         s1_char;
    logic         s1_result;
    logic         s1_go;
    logic         step;
    logic [136:0] mac;
    parse_phase_t st_phase;
    logic [127:0] st_accum;
    logic         st_sign;
    logic         st_ovf;
    logic [15:0]  st_count;
    logic [15:0]  st_mark;
    logic         res_invalid;

    assign in_code        = s_tdata[7:0];
    assign in_entry.cls   = sym_class_t'(s_tdata[9:8]);
    assign in_entry.value = s_tdata[17:10];

    // Handshake: stage 1 moves on unless it holds a result the output cannot take.
    assign s1_char   = s1_valid_reg && (s1_load_reg == REQ_CHAR);
    assign s1_result = s1_char && s1_last_reg;
    assign s1_go     = !s1_result || !m_tvalid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || s1_go;
    assign s_accept  = s_tvalid && s_tready;
    assign step      = s1_char && s1_go;

    // APB register access.
    assign pready = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_RADIX:       prdata = {23'd0, radix_reg};
            REG_SIGN_ENABLE: prdata = {31'd0, sign_enable_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg       <= RADIX_RESET;
            sign_enable_reg <= SIGN_ENABLE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_RADIX) begin
                radix_reg <= pwdata[8:0];
            end else begin
                sign_enable_reg <= pwdata[0];
            end
        end
    end

    // Symbol map: written by load items, read for every accepted item.
    always_ff @(posedge aclk) begin
        if (s_accept && (s_tuser == REQ_MAP_LOAD)) begin
            map_mem[in_code] <= in_entry;
        end
        if (s_accept) begin
            rd_entry_reg <= map_mem[in_code];
        end
    end

    // Valid bits mark entries loaded since reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_valid_reg <= '0;
            rd_hit_reg    <= 1'b0;
        end else if (s_accept) begin
            rd_hit_reg <= map_valid_reg[in_code];
            if (s_tuser == REQ_MAP_LOAD) begin
                map_valid_reg[in_code] <= 1'b1;
            end
        end
    end

    // Stage 1 item register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_load_reg <= s_tuser;
            s1_last_reg <= s_tlast;
            s1_code_reg <= in_code;
        end
    end

    // Unloaded entries read as their reset value.
    assign entry = rd_hit_reg ? rd_entry_reg : default_entry(s1_code_reg);

    // Accumulator multiply-add: value * radix + digit.
    assign mac = {9'd0, accum_reg} * {128'd0, radix_reg} + {129'd0, entry.value};

    // Parse step and state clear after the last character.
    always_comb begin
        st_phase = phase_reg;
        st_accum = accum_reg;
        st_sign  = sign_reg;
        st_ovf   = ovf_reg;
        st_count = (count_reg < COUNT_LIMIT) ? count_reg + 16'd1 : count_reg;
        st_mark  = mark_reg;

        case (phase_reg)
            PH_LEAD, PH_DIGITS: begin
                if (entry.cls == CLS_DIGIT) begin
                    st_phase = PH_DIGITS;
                    st_mark  = st_count;
                    if (!ovf_reg) begin
                        if (mac[136:128] != 9'd0) begin
                            st_ovf   = 1'b1;
                            st_accum = '1;
                        end else begin
                            st_accum = mac[127:0];
                        end
                    end
                end else if (phase_reg == PH_DIGITS) begin
                    st_phase = PH_DONE;
                end else if (entry.cls == CLS_SKIP) begin
                    st_phase = PH_LEAD;
                end else if ((entry.cls == CLS_MINUS) && sign_enable_reg) begin
                    st_sign = !sign_reg;
                end else begin
                    st_phase = PH_BAD;
                end
            end
            default: begin
                st_phase = phase_reg;
            end
        endcase

        phase_next = phase_reg;
        accum_next = accum_reg;
        sign_next  = sign_reg;
        ovf_next   = ovf_reg;
        count_next = count_reg;
        mark_next  = mark_reg;
        if (step) begin
            if (s1_last_reg) begin
                phase_next = PH_LEAD;
                accum_next = '0;
                sign_next  = 1'b0;
                ovf_next   = 1'b0;
                count_next = '0;
                mark_next  = '0;
            end else begin
                phase_next = st_phase;
                accum_next = st_accum;
                sign_next  = st_sign;
                ovf_next   = st_ovf;
                count_next = st_count;
                mark_next  = st_mark;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            accum_reg <= '0;
            sign_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            count_reg <= '0;
            mark_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            sign_reg  <= sign_next;
            ovf_reg   <= ovf_next;
            count_reg <= count_next;
            mark_reg  <= mark_next;
        end
    end

    // A string without digits, with a bad lead, or in a base below two is invalid.
    assign res_invalid = (st_phase == PH_LEAD) || (st_phase == PH_BAD) || (radix_reg < 9'd2);

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step && s1_last_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && s1_last_reg) begin
            if (res_invalid) begin
                m_value_low_reg  <= '0;
                m_value_high_reg <= '0;
                m_negative_reg   <= 1'b0;
                m_status_reg     <= ST_INVALID;
                m_end_count_reg  <= '0;
            end else begin
                m_value_low_reg  <= st_accum[63:0];
                m_value_high_reg <= st_accum[127:64];
                m_negative_reg   <= st_sign;
                m_status_reg     <= st_ovf ? ST_RANGE : ST_OK;
                m_end_count_reg  <= st_mark;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_end_count_reg, m_status_reg, m_negative_reg,
                       m_value_high_reg, m_value_low_reg};

    // Checks.
    `RSTU_ASSERT_NOW(a_stall_cause, !s_tready, s1_valid_reg && m_tvalid_reg,
        "input stalled without a blocked result")
    `RSTU_ASSERT_NEXT(a_clear_after_last, step && s1_last_reg,
        (phase_reg == PH_LEAD) && (count_reg == 16'd0) && !ovf_reg && (accum_reg == 128'd0),
        "parse state not cleared after a result")
    `RSTU_ASSERT_NOW(a_invalid_zero, m_tvalid_reg && (m_status_reg == ST_INVALID),
        (m_value_low_reg == 64'd0) && (m_value_high_reg == 64'd0) && (m_end_count_reg == 16'd0),
        "invalid result carries data")
    `RSTU_ASSERT_NOW(a_range_saturated, m_tvalid_reg && (m_status_reg == ST_RANGE),
        (&m_value_low_reg) && (&m_value_high_reg),
        "out of range result not saturated")

endmodule
